// File: hw/rtl/pts_pkg.sv
// shared types and constants of the priority thread scheduler
// no dependencies
package pts_pkg;

  localparam int unsigned SlotsDef = 16;
  localparam int unsigned PrioLevelsDef = 64;
  localparam logic [7:0] SliceReset = 8'd4;
  localparam logic [30:0] TidMask = 31'h7fffffff;

  // slot status codes
  typedef enum logic [2:0] {
    StFree     = 3'd0,
    StRunning  = 3'd1,
    StReady    = 3'd2,
    StBlocked  = 3'd3,
    StSleeping = 3'd4
  } status_e;

  // event codes
  typedef enum logic [2:0] {
    OpTick   = 3'd0,
    OpCreate = 3'd1,
    OpBlock  = 3'd2,
    OpUnblk  = 3'd3,
    OpYield  = 3'd4,
    OpExit   = 3'd5,
    OpSetPri = 3'd6,
    OpSleep  = 3'd7
  } op_e;

  // error codes
  localparam logic [1:0] ErrOk     = 2'd0;
  localparam logic [1:0] ErrNoSlot = 2'd1;
  localparam logic [1:0] ErrNotBlk = 2'd2;
  localparam logic [1:0] ErrIdle   = 2'd3;

  // search kinds run through the cell chain
  typedef enum logic [1:0] {
    SrchReady = 2'd0,
    SrchSleep = 2'd1,
    SrchFree  = 2'd2
  } srch_e;

  // candidate handed from cell to cell
  typedef struct packed {
    logic        found;
    logic [7:0]  slot;
    logic [7:0]  prio;
    logic [63:0] wake;
    logic [31:0] age;
  } cand_t;

endpackage

// File: hw/rtl/pts_cell.sv
// one cell of the search chain: compares its slot against the passing candidate
// depends on pts_pkg
module pts_cell
  import pts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  srch_e       kind_i,
  input  logic [63:0] now_i,
  input  logic [7:0]  slot_i,
  input  status_e     status_i,
  input  logic [7:0]  prio_i,
  input  logic [63:0] wake_i,
  input  logic [31:0] age_i,
  input  cand_t       cand_i,
  output cand_t       cand_o
);

  logic  take;
  cand_t cand_d, cand_q;

  // decide whether this slot beats the incoming candidate
  always_comb begin
    take = 1'b0;
    case (kind_i)
      SrchReady: begin
        if (status_i == StReady) begin
          take = !cand_i.found || prio_i > cand_i.prio ||
                 (prio_i == cand_i.prio && age_i > cand_i.age);
        end
      end
      SrchSleep: begin
        if (status_i == StSleeping && wake_i <= now_i) begin
          take = !cand_i.found || wake_i < cand_i.wake ||
                 (wake_i == cand_i.wake && (prio_i > cand_i.prio ||
                 (prio_i == cand_i.prio && age_i > cand_i.age)));
        end
      end
      SrchFree: begin
        take = status_i == StFree && !cand_i.found;
      end
      default: take = 1'b0;
    endcase
    cand_d = cand_i;
    if (take) begin
      cand_d.found = 1'b1;
      cand_d.slot  = slot_i;
      cand_d.prio  = prio_i;
      cand_d.wake  = wake_i;
      cand_d.age   = age_i;
    end
  end

  // candidate register toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else if (en_i) begin
      cand_q <= cand_d;
    end
  end

  assign cand_o = cand_q;

endmodule

// File: hw/rtl/priority_thread_scheduler_unit.sv
// Priority thread scheduler over a table of SLOTS thread slots; one event per
// input item gives one result item. Each search (ready front, due sleeper, free
// slot) walks a row of SLOTS-1 cells, one cell per cycle. An unblock runs no
// search, while block/exit/sleep and yield each run a ready search. A create,
// set priority or tick that ends in a preemption runs a further ready search
// through the yield path. A tick repeats the sleeper search once per woken
// sleeper. The next item is taken once the result register is free.
// depends on pts_pkg and pts_cell
module priority_thread_scheduler_unit
  import pts_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDef,
  parameter int unsigned PRIO_LEVELS = PrioLevelsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[2:0], target_slot[6:3], priority_req[12:7], wake_tick[76:13],
  // current_is_user[77], zero fill to 80
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // running_slot[3:0], running_tid[34:4], switched[35], woken_count[40:36],
  // new_slot[44:41], new_tid[75:45], error[77:76], idle_time[141:78],
  // kern_time[205:142], usr_time[269:206], zero fill to 272
  output logic [271:0] m_axis_tdata
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [7:0] PrioMax = 8'(PRIO_LEVELS - 1);

  typedef enum logic [3:0] {
    Idle, Decode, Search, TickWake, TickPre, Create2, Preempt, Yield, Dispatch,
    Emit
  } fsm_e;

  // slot table
  status_e     status_q [SLOTS];
  logic [7:0]  prio_q   [SLOTS];
  logic [63:0] wake_q   [SLOTS];
  logic [31:0] stamp_q  [SLOTS];
  logic [30:0] tid_q    [SLOTS];

  logic [31:0] order_q;
  logic [SW-1:0] cur_q;
  logic [63:0] now_q, idle_q, kern_q, user_q;
  logic [7:0]  slice_q, tslice_q;
  logic [30:0] ntid_q;

  fsm_e        state_q;
  srch_e       kind_q;
  fsm_e        ret_q;
  logic [CW-1:0] cnt_q;
  logic [2:0]  op_q;
  logic [SW-1:0] tgt_q;
  logic [7:0]  preq_q;
  logic [63:0] wreq_q;
  logic        user_q_in;
  logic        sw_q;
  logic [4:0]  woken_q;
  logic [SW-1:0] nslot_q;
  logic [30:0] ntido_q;
  logic [1:0]  err_q;
  logic        last_q;
  cand_t       res_q;
  logic        busy;

  // cell chain
  cand_t chain [SLOTS];
  logic [63:0] now_srch;
  assign chain[0] = '0;
  assign now_srch = now_q;
  assign busy = state_q == Search;

  for (genvar g = 1; g < SLOTS; g++) begin : g_cell
    pts_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (busy),
      .kind_i  (kind_q),
      .now_i   (now_srch),
      .slot_i  (8'(g)),
      .status_i(status_q[g]),
      .prio_i  (prio_q[g]),
      .wake_i  (wake_q[g]),
      .age_i   (order_q - stamp_q[g]),
      .cand_i  (chain[g-1]),
      .cand_o  (chain[g])
    );
  end

  assign cfg_ready = state_q == Idle;
  assign s_axis_tready = state_q == Idle && !m_axis_tvalid;

  logic [7:0] preq_in;
  assign preq_in = ({2'b0, s_axis_tdata[12:7]} > PrioMax) ? PrioMax
                                                          : {2'b0, s_axis_tdata[12:7]};

  logic [30:0] ntid_inc;
  assign ntid_inc = ntid_q + 31'd1;

  // sequencer and slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      ret_q <= Idle;
      kind_q <= SrchReady;
      cnt_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        status_q[i] <= StFree;
        prio_q[i] <= '0;
        tid_q[i] <= '0;
      end
      status_q[1] <= StRunning;
      prio_q[1] <= (8'd31 > PrioMax) ? PrioMax : 8'd31;
      tid_q[1] <= 31'd1;
      tid_q[0] <= 31'd2;
      order_q <= '0;
      cur_q <= SW'(1);
      now_q <= '0;
      idle_q <= '0;
      kern_q <= '0;
      user_q <= '0;
      slice_q <= '0;
      tslice_q <= SliceReset;
      ntid_q <= 31'd3;
      m_axis_tvalid <= 1'b0;
      res_q <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state_q)
        Idle: begin
          if (cfg_valid) tslice_q <= cfg_data;
          if (s_axis_tvalid && s_axis_tready) begin
            op_q <= s_axis_tdata[2:0];
            tgt_q <= SW'(s_axis_tdata[6:3]);
            last_q <= (32'(s_axis_tdata[6:3]) >= SLOTS);
            preq_q <= preq_in;
            wreq_q <= s_axis_tdata[76:13];
            user_q_in <= s_axis_tdata[77];
            sw_q <= 1'b0;
            woken_q <= '0;
            nslot_q <= '0;
            ntido_q <= '0;
            err_q <= ErrOk;
            state_q <= Decode;
          end
        end
        Decode: begin
          case (op_e'(op_q))
            OpTick: begin
              if (cur_q == '0) idle_q <= idle_q + 64'd1;
              else if (user_q_in) user_q <= user_q + 64'd1;
              else kern_q <= kern_q + 64'd1;
              now_q <= now_q + 64'd1;
              kind_q <= SrchSleep;
              ret_q <= TickWake;
              cnt_q <= '0;
              state_q <= Search;
            end
            OpCreate: begin
              kind_q <= SrchFree;
              ret_q <= Create2;
              cnt_q <= '0;
              state_q <= Search;
            end
            OpUnblk: begin
              if (tgt_q == '0 || last_q || status_q[tgt_q] != StBlocked) begin
                err_q <= ErrNotBlk;
              end else begin
                status_q[tgt_q] <= StReady;
                stamp_q[tgt_q] <= order_q;
                order_q <= order_q + 32'd1;
              end
              state_q <= Emit;
            end
            OpYield: state_q <= Yield;
            default: begin
              if (cur_q == '0) begin
                err_q <= ErrIdle;
                state_q <= Emit;
              end else if (op_e'(op_q) == OpSetPri) begin
                prio_q[cur_q] <= preq_q;
                kind_q <= SrchReady;
                ret_q <= Preempt;
                cnt_q <= '0;
                state_q <= Search;
              end else begin
                if (op_e'(op_q) == OpBlock) status_q[cur_q] <= StBlocked;
                else if (op_e'(op_q) == OpExit) status_q[cur_q] <= StFree;
                else begin
                  status_q[cur_q] <= StSleeping;
                  wake_q[cur_q] <= wreq_q;
                  stamp_q[cur_q] <= order_q;
                  order_q <= order_q + 32'd1;
                end
                kind_q <= SrchReady;
                ret_q <= Dispatch;
                cnt_q <= '0;
                state_q <= Search;
              end
            end
          endcase
        end
        // walk the chain until the counter reaches SLOTS-1, then latch the last cell's candidate
        Search: begin
          if (cnt_q == CW'(SLOTS - 1)) begin
            res_q <= chain[SLOTS-1];
            state_q <= ret_q;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        TickWake: begin
          if (res_q.found) begin
            status_q[SW'(res_q.slot)] <= StReady;
            stamp_q[SW'(res_q.slot)] <= order_q;
            order_q <= order_q + 32'd1;
            woken_q <= woken_q + 5'd1;
            kind_q <= SrchSleep;
            ret_q <= TickWake;
          end else begin
            kind_q <= SrchReady;
            ret_q <= TickPre;
          end
          cnt_q <= '0;
          state_q <= Search;
        end
        TickPre: begin
          if (res_q.found && (cur_q == '0 || prio_q[cur_q] < res_q.prio)) begin
            state_q <= Yield;
          end else begin
            if (slice_q < 8'd255 && (slice_q + 8'd1) >= tslice_q) state_q <= Yield;
            else if (slice_q == 8'd255 && slice_q >= tslice_q) state_q <= Yield;
            else begin
              if (slice_q < 8'd255) slice_q <= slice_q + 8'd1;
              state_q <= Emit;
            end
          end
        end
        Create2: begin
          if (!res_q.found) begin
            err_q <= ErrNoSlot;
            state_q <= Emit;
          end else begin
            prio_q[SW'(res_q.slot)] <= preq_q;
            tid_q[SW'(res_q.slot)] <= ntid_q;
            nslot_q <= SW'(res_q.slot);
            ntido_q <= ntid_q;
            ntid_q <= (ntid_inc == '0) ? 31'd1 : ntid_inc;
            status_q[SW'(res_q.slot)] <= StReady;
            stamp_q[SW'(res_q.slot)] <= order_q;
            order_q <= order_q + 32'd1;
            kind_q <= SrchReady;
            ret_q <= Preempt;
            cnt_q <= '0;
            state_q <= Search;
          end
        end
        Preempt: begin
          if (res_q.found && (cur_q == '0 || prio_q[cur_q] < res_q.prio)) state_q <= Yield;
          else state_q <= Emit;
        end
        // requeue running thread then search for the front
        Yield: begin
          if (cur_q != '0) begin
            status_q[cur_q] <= StReady;
            stamp_q[cur_q] <= order_q;
            order_q <= order_q + 32'd1;
          end
          kind_q <= SrchReady;
          ret_q <= Dispatch;
          cnt_q <= '0;
          state_q <= Search;
        end
        Dispatch: begin
          if (res_q.found) status_q[SW'(res_q.slot)] <= StRunning;
          sw_q <= (res_q.found ? SW'(res_q.slot) : '0) != cur_q;
          cur_q <= res_q.found ? SW'(res_q.slot) : '0;
          slice_q <= '0;
          state_q <= Emit;
        end
        Emit: begin
          m_axis_tvalid <= 1'b1;
          state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  // result packing
  assign m_axis_tdata = {2'b0, user_q, kern_q, idle_q, err_q, ntido_q, 4'(nslot_q),
                         woken_q, sw_q, tid_q[cur_q], 4'(cur_q)};

endmodule
